// File: hdl/rfid_ascii_hex_frame_decoder_unit_macros.svh
// assertion helpers used by the frame decoder
`ifndef RFID_ASCII_HEX_FRAME_DECODER_UNIT_MACROS_SVH
`define RFID_ASCII_HEX_FRAME_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RFID_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfid decoder check failed");

// next-cycle implication, checked outside reset
`define RFID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfid decoder check failed");

`endif

// File: hdl/rfid_pkg.sv
package rfid_pkg;

	// frame bytes and character count
	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] END_BYTE   = 8'h03;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [3:0] CHAR_COUNT = 4'd12;
	localparam int         NUM_BYTES  = 6;
	localparam int         CHECK_BYTES = 5;

	// card slots
	localparam int NUM_SLOTS = 4;
	localparam int CARD_REGS = 4;
	localparam int MASK_W    = 4;
	localparam int ID_W      = 32;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_C   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_ENABLE = 3'd4;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_BAD_CHECK = 2'd1,
		ST_BAD_END   = 2'd2
	} frame_status_t;

	typedef enum logic {
		FS_HUNT  = 1'b0,
		FS_FRAME = 1'b1
	} frame_state_t;

	typedef struct packed {
		logic [CARD_REGS-1:0][ID_W-1:0] card_id;
		logic [MASK_W-1:0]              slot_enable;
	} cfg_regs_t;

	// packed from the top bit down, so frame_status lands in the lowest bits
	typedef struct packed {
		logic [1:0]        pad;
		logic [MASK_W-1:0] match_mask;
		logic [7:0]        received_check;
		logic [7:0]        computed_check;
		logic [ID_W-1:0]   tag_id;
		logic [7:0]        tag_version;
		frame_status_t     frame_status;
	} result_t;

	// ascii hex digit to nibble value, no validity check
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		hex_value = (c > CHAR_NINE) ? (c - CHAR_SEVEN) : (c - CHAR_ZERO);
	endfunction

endpackage

// File: hdl/rfid_cfg_regs.sv
module rfid_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rfid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rfid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output rfid_pkg::cfg_regs_t                cfg
);
	import rfid_pkg::*;

	cfg_regs_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CARD_ID_A: begin
					cfg_q.card_id[0] <= cfg_wdata;
				end
				REG_CARD_ID_B: begin
					cfg_q.card_id[1] <= cfg_wdata;
				end
				REG_CARD_ID_C: begin
					cfg_q.card_id[2] <= cfg_wdata;
				end
				REG_CARD_ID_D: begin
					cfg_q.card_id[3] <= cfg_wdata;
				end
				REG_SLOT_ENABLE: begin
					cfg_q.slot_enable <= cfg_wdata[MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/rfid_frame_decode.sv
`include "rfid_ascii_hex_frame_decoder_unit_macros.svh"

module rfid_frame_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [7:0]                    in_byte,
	input  rfid_pkg::cfg_regs_t           cfg,
	input  logic                          out_ready,
	output logic                          advance,
	output logic                          out_valid,
	output rfid_pkg::result_t             result
);
	import rfid_pkg::*;

	frame_state_t state_q, state_d;
	logic [3:0]   count_q, count_d;
	logic [NUM_BYTES-1:0][7:0] dec_q;
	logic         out_valid_q;
	result_t      result_q;

	logic         is_result;
	logic         write_char;
	logic [7:0]   nibble;
	logic [2:0]   byte_idx;
	logic [7:0]   chk;
	logic [ID_W-1:0] id;
	frame_status_t status;
	logic [MASK_W-1:0] mask;
	result_t      result_d;

	assign nibble   = hex_value(in_byte);
	assign byte_idx = count_q[3:1];

	// control decode per state
	always_comb begin
		is_result  = 1'b0;
		write_char = 1'b0;
		case (state_q)
			FS_HUNT: begin
			end
			FS_FRAME: begin
				is_result  = (count_q == CHAR_COUNT);
				write_char = (count_q != CHAR_COUNT);
			end
			default: begin
			end
		endcase
	end

	// take the word unless a result would overwrite one still waiting
	assign advance = in_valid && (!is_result || !out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		case (state_q)
			FS_HUNT: begin
				if (in_byte == START_BYTE) begin
					state_d = FS_FRAME;
					count_d = '0;
				end
			end
			FS_FRAME: begin
				if (count_q == CHAR_COUNT) begin
					state_d = FS_HUNT;
					count_d = '0;
				end else begin
					count_d = count_q + 4'd1;
				end
			end
			default: begin
				state_d = FS_HUNT;
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_HUNT;
			count_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// character packing, high nibble first
	always_ff @(posedge clk) begin
		if (advance && write_char) begin
			if (!count_q[0]) begin
				dec_q[byte_idx] <= {nibble[3:0], 4'h0};
			end else begin
				dec_q[byte_idx] <= dec_q[byte_idx] + nibble;
			end
		end
	end

	// checksum, id and slot match on the end word
	always_comb begin
		chk = '0;
		for (int i = 0; i < CHECK_BYTES; i++) begin
			chk = chk ^ dec_q[i];
		end
		id = {dec_q[1], dec_q[2], dec_q[3], dec_q[4]};
		if (in_byte != END_BYTE) begin
			status = ST_BAD_END;
		end else if (chk != dec_q[5]) begin
			status = ST_BAD_CHECK;
		end else begin
			status = ST_VALID;
		end
		mask = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < NUM_SLOTS) begin
				mask[i] = (status == ST_VALID) && cfg.slot_enable[i] &&
					(cfg.card_id[i] == id);
			end
		end
		result_d.pad            = '0;
		result_d.match_mask     = mask;
		result_d.received_check = dec_q[5];
		result_d.computed_check = chk;
		result_d.tag_id         = id;
		result_d.tag_version    = dec_q[0];
		result_d.frame_status   = status;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_result) begin
			result_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	`RFID_ASSERT_IMP(a_count_range, state_q == FS_FRAME, count_q <= CHAR_COUNT)
	`RFID_ASSERT_IMP(a_mask_only_valid, out_valid_q && result_q.frame_status != ST_VALID,
		result_q.match_mask == '0)
	`RFID_ASSERT_NEXT(a_result_loaded, advance && is_result, out_valid_q)
	`RFID_ASSERT_NEXT(a_back_to_hunt, advance && is_result, state_q == FS_HUNT)

endmodule

// File: hdl/rfid_ascii_hex_frame_decoder_unit.sv
// throughput: one byte per cycle; the decode is combinational logic between the
// input register and the result register; a waiting result stalls input only when the next frame's end word arrives
// reset: arst_n clears the hunt state, valid flags and the card registers at once;
// the decoded byte store is not reset and is always filled before it is read
module rfid_ascii_hex_frame_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: rx_byte [7:0]
	input  logic [rfid_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: frame_status [1:0], tag_version [9:2], tag_id [41:10],
	// computed_check [49:42], received_check [57:50], match_mask [61:58], zero [63:62]
	output logic [rfid_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [rfid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfid_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rfid_pkg::*;

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      advance;
	cfg_regs_t cfg;
	result_t   result;

	// input register
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	rfid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rfid_frame_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_byte   (byte_s1),
		.cfg       (cfg),
		.out_ready (m_axis_tready),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.result    (result)
	);

	assign m_axis_tdata = result;

endmodule
